### hw/rtl/smf_pkg.sv
// Shared types and constants for the sliding median filter.
// Depends on nothing; imported by the top level.
`default_nettype none

package smf_pkg;

    // Width and reset value of the half-window configuration register.
    localparam int HW_BITS = 4;
    localparam logic [HW_BITS-1:0] HW_RESET = 4'd1;

    // Sequencer states of the rank-counting engine.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_XDATA,
        S_SCAN,
        S_DECIDE,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

### hw/rtl/smf_window_ram.sv
// Sample history held as a circular buffer with one write and one registered read.
// Reads are addressed by age (zero is the newest sample). No package dependencies.
`default_nettype none

module smf_window_ram #(
    parameter int DEPTH     = 17,
    parameter int DATA_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    input  wire logic signed [DATA_BITS-1:0]   i_push_data,
    input  wire logic [$clog2(DEPTH+1)-1:0]    i_rd_index,
    output logic signed [DATA_BITS-1:0]        o_rd_data
);

    localparam int IW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int PW = IW + 1;

    logic signed [DATA_BITS-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] n_wp;
    logic [PW-1:0] wp_e;
    logic [PW-1:0] idx_e;
    logic [PW-1:0] phys;

    always_comb begin
        n_wp  = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        wp_e  = PW'(r_wp);
        idx_e = PW'(i_rd_index);
        // Age counts backward from the write pointer, wrapping at the depth.
        if (wp_e >= idx_e) begin
            phys = wp_e - idx_e;
        end else begin
            phys = wp_e + PW'(DEPTH) - idx_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
        end else if (i_push) begin
            r_wp <= n_wp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[n_wp] <= i_push_data;
        end
        o_rd_data <= r_mem[phys[AW-1:0]];
    end

endmodule

`default_nettype wire

### hw/rtl/sliding_median_filter.sv
// Top level of the sliding-window median filter: sequencer and rank counter.
// Depends on smf_pkg and smf_window_ram.
`default_nettype none

// Usage
// Samples of one spectrum enter on the input channel (i_valid / o_ready), one
// transaction per sample; the last sample carries i_end_of_spectrum. Each
// position gets the upper median of the samples within h = min(half_window,
// MAX_HALF_WINDOW) on either side, with the window cut at the spectrum edges.
// Results leave on the output channel (o_valid / i_ready), h samples behind
// the input; the end flag flushes all waiting positions, and the final result
// of a spectrum carries o_last_of_run. half_window is written on i_cfg_wr_en;
// the user must write it only while the block is idle, as the block itself
// does not enforce this. It resets to 1. A single comparator ranks the
// window of n <= 2h+1 samples. Each candidate is fetched, compared with
// the n entries in turn, then decided on; the rank loop bounds each result.
// The input is accepted only while the sequencer is idle, one transaction at
// a time. The output register decouples the sides: the next sample is taken
// while a result waits, and a stalled receiver only holds the sequencer once
// it has a further result to hand over. Synchronous reset empties the
// spectrum counters and the output; the sample store needs no clearing.

module sliding_median_filter
    import smf_pkg::*;
#(
    parameter int MAX_HALF_WINDOW = 8,
    parameter int SAMPLE_BITS     = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [HW_BITS-1:0]            i_cfg_wr_data,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                          i_end_of_spectrum,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0]      o_median_value,
    output logic                               o_last_of_run
);

    localparam int DEPTH = 2 * MAX_HALF_WINDOW + 1;
    localparam int CAP   = 2 * MAX_HALF_WINDOW + 15;
    localparam int CW    = $clog2(CAP + 1);
    localparam int IW    = $clog2(DEPTH + 1);
    localparam int NW    = $clog2(MAX_HALF_WINDOW + 2);

    t_state r_state, n_state;
    logic [HW_BITS-1:0] r_hw, n_hw;
    logic [CW-1:0] r_seen, n_seen;
    logic [CW-1:0] r_og, n_og;
    logic [CW-1:0] r_pending, n_pending;
    logic r_end, n_end;
    logic [NW-1:0] r_count, n_count;
    logic [IW-1:0] r_lo, n_lo, r_hi, n_hi, r_i, n_i, r_j, n_j, r_k, n_k;
    logic [IW-1:0] r_below, n_below, r_atb, n_atb;
    logic signed [SAMPLE_BITS-1:0] r_x, n_x, r_median, n_median;
    logic r_ov, n_ov;
    logic signed [SAMPLE_BITS-1:0] r_out_med, n_out_med;
    logic r_out_last, n_out_last;

    logic accept;
    logic [IW-1:0] rd_index;
    logic signed [SAMPLE_BITS-1:0] rd_data;

    // Window bounds for the oldest waiting position.
    logic [CW-1:0] h_cw, d, newer, older, lo_w;
    logic [CW:0] hi_w, hi_c, lo_c;
    logic [IW-1:0] n_win;
    logic [CW-1:0] seen_a, og_a, pend_a;
    logic found, emit_last;

    assign accept = i_valid && o_ready;

    smf_window_ram #(
        .DEPTH     (DEPTH),
        .DATA_BITS (SAMPLE_BITS)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_push_data (i_sample),
        .i_rd_index  (rd_index),
        .o_rd_data   (rd_data)
    );

    always_comb begin
        h_cw  = (CW'(r_hw) > CW'(MAX_HALF_WINDOW)) ? CW'(MAX_HALF_WINDOW) : CW'(r_hw);
        d     = r_pending - 1'b1;
        newer = (h_cw < d) ? h_cw : d;
        older = (h_cw < r_og) ? h_cw : r_og;
        lo_w  = d - newer;
        hi_w  = {1'b0, d} + {1'b0, older};
        hi_c  = (hi_w >= (CW + 1)'(DEPTH)) ? (CW + 1)'(DEPTH - 1) : hi_w;
        lo_c  = ({1'b0, lo_w} > hi_c) ? hi_c : {1'b0, lo_w};
        n_win = hi_c[IW-1:0] - lo_c[IW-1:0] + 1'b1;

        // Counter update for an arriving sample; a saturated count moves
        // the emitted count down instead so their difference stays exact.
        seen_a = r_seen;
        og_a   = r_og;
        if (r_seen < CW'(CAP)) begin
            seen_a = r_seen + 1'b1;
        end else if (r_og != '0) begin
            og_a = r_og - 1'b1;
        end
        pend_a = (seen_a >= og_a) ? seen_a - og_a : '0;

        found     = (r_below <= r_k) && (r_k < r_atb);
        emit_last = r_end && ((r_pending == CW'(1)) ||
                              (r_count == NW'(MAX_HALF_WINDOW)));
    end

    always_comb begin
        case (r_state)
            S_SETUP:  rd_index = lo_c[IW-1:0];
            S_SCAN:   rd_index = r_j + 1'b1;
            S_DECIDE: rd_index = r_i + 1'b1;
            default:  rd_index = r_lo;
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_hw       = i_cfg_wr_en ? i_cfg_wr_data : r_hw;
        n_seen     = r_seen;
        n_og       = r_og;
        n_pending  = r_pending;
        n_end      = r_end;
        n_count    = r_count;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_below    = r_below;
        n_atb      = r_atb;
        n_x        = r_x;
        n_median   = r_median;
        n_ov       = r_ov && !i_ready;
        n_out_med  = r_out_med;
        n_out_last = r_out_last;
        o_ready    = (r_state == S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_seen    = seen_a;
                    n_og      = og_a;
                    n_pending = pend_a;
                    n_end     = i_end_of_spectrum;
                    n_count   = '0;
                    if (i_end_of_spectrum) begin
                        if (pend_a != '0) begin
                            n_state = S_SETUP;
                        end else begin
                            n_seen = '0;
                            n_og   = '0;
                        end
                    end else if (pend_a > h_cw) begin
                        n_state = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                n_lo    = lo_c[IW-1:0];
                n_hi    = hi_c[IW-1:0];
                n_i     = lo_c[IW-1:0];
                n_k     = n_win >> 1;
                n_state = S_XDATA;
            end
            S_XDATA: begin
                // Candidate arrives; start scanning the window from its low end.
                n_x     = rd_data;
                n_j     = r_lo;
                n_below = '0;
                n_atb   = '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (rd_data < r_x) begin
                    n_below = r_below + 1'b1;
                end
                if (rd_data <= r_x) begin
                    n_atb = r_atb + 1'b1;
                end
                n_j = r_j + 1'b1;
                if (r_j == r_hi) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (found || (r_i == r_hi)) begin
                    n_median = r_x;
                    n_state  = S_EMIT;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_XDATA;
                end
            end
            S_EMIT: begin
                if (!r_ov || i_ready) begin
                    n_ov       = 1'b1;
                    n_out_med  = r_median;
                    n_out_last = emit_last;
                    n_og       = (r_og < CW'(CAP)) ? r_og + 1'b1 : r_og;
                    n_pending  = r_pending - 1'b1;
                    n_count    = r_count + 1'b1;
                    if (r_end && !emit_last) begin
                        n_state = S_SETUP;
                    end else begin
                        n_state = S_IDLE;
                        if (r_end) begin
                            n_seen = '0;
                            n_og   = '0;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hw    <= HW_RESET;
            r_seen  <= '0;
            r_og    <= '0;
            r_count <= '0;
            r_ov    <= 1'b0;
            r_below <= '0;
            r_atb   <= '0;
            r_lo    <= '0;
            r_hi    <= '0;
            r_i     <= '0;
        end else begin
            r_state <= n_state;
            r_hw    <= n_hw;
            r_seen  <= n_seen;
            r_og    <= n_og;
            r_count <= n_count;
            r_ov    <= n_ov;
            r_below <= n_below;
            r_atb   <= n_atb;
            r_lo    <= n_lo;
            r_hi    <= n_hi;
            r_i     <= n_i;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pending  <= n_pending;
        r_end      <= n_end;
        r_j        <= n_j;
        r_k        <= n_k;
        r_x        <= n_x;
        r_median   <= n_median;
        r_out_med  <= n_out_med;
        r_out_last <= n_out_last;
    end

    assign o_valid        = r_ov;
    assign o_median_value = r_out_med;
    assign o_last_of_run  = r_out_last;

    // A count of smaller entries can never exceed the count of entries at or below.
    a_rank_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_below <= r_atb)
        else $error("rank counts out of order");

    // The upper median always exists, so the last candidate must qualify.
    a_median_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE) && (r_i == r_hi) |-> found)
        else $error("no candidate met the median rank");

    // Results given never run ahead of samples seen.
    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_og <= r_seen)
        else $error("emitted count exceeds sample count");

    // The scan window stays inside the store.
    a_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_lo <= r_hi) && (r_hi < IW'(DEPTH)))
        else $error("window bounds invalid");

endmodule

`default_nettype wire

### dv/sliding_median_filter_tb.sv
// Self-checking testbench for the sliding median filter.
// It holds a median scoreboard class and the top module that drives the block.
// It depends on smf_pkg and the filter's RTL only.
`timescale 1ns / 100ps

class median_scoreboard;

    localparam int MAX_HALF = 8;
    localparam int DEPTH    = 2 * MAX_HALF + 1;
    localparam int SEEN_CAP = 2 * MAX_HALF + 15;

    typedef struct {
        logic signed [15:0] median;
        logic               last;
    } t_expect;

    logic signed [15:0]          window [DEPTH];
    int unsigned                 seen;
    int unsigned                 given;
    logic [smf_pkg::HW_BITS-1:0] half_window;
    t_expect                     expected_medians [$];
    int unsigned                 error_count;
    int unsigned                 results_seen;

    function new();
        foreach (window[i]) window[i] = '0;
        seen         = 0;
        given        = 0;
        half_window  = smf_pkg::HW_RESET;
        error_count  = 0;
        results_seen = 0;
    endfunction

    function void set_half_window(logic [smf_pkg::HW_BITS-1:0] value);
        half_window = value;
    endfunction

    function int unsigned outstanding();
        return expected_medians.size();
    endfunction

    // Upper median of window entries lo..hi: the entry whose rank range
    // covers element n/2 of the sorted set.
    function logic signed [15:0] rank_median(int unsigned lo, int unsigned hi);
        int unsigned target;
        int unsigned below;
        int unsigned at_or_below;
        target = (hi - lo + 1) / 2;
        for (int unsigned i = lo; i <= hi; i++) begin
            below       = 0;
            at_or_below = 0;
            for (int unsigned j = lo; j <= hi; j++) begin
                if (window[j] < window[i]) below++;
                if (window[j] <= window[i]) at_or_below++;
            end
            if (below <= target && target < at_or_below) return window[i];
        end
        return window[lo];
    endfunction

    // Predict the result for the oldest waiting position.
    function void push_median(int unsigned waiting, int unsigned h, logic last);
        int unsigned d;
        int unsigned lo;
        int unsigned hi;
        t_expect     item;
        d  = waiting - 1;
        lo = d - ((h < d) ? h : d);
        hi = d + ((h < given) ? h : given);
        if (hi >= DEPTH) hi = DEPTH - 1;
        if (lo > hi) lo = hi;
        item.median = rank_median(lo, hi);
        item.last   = last;
        expected_medians.insert(expected_medians.size(), item);
        if (given < SEEN_CAP) given++;
    endfunction

    // Called for every accepted sample transaction.
    function void note_sample(logic signed [15:0] value, logic eos);
        int unsigned h;
        int unsigned waiting;
        int unsigned count;
        h = (half_window > MAX_HALF) ? MAX_HALF : half_window;
        for (int i = DEPTH - 1; i > 0; i--) window[i] = window[i - 1];
        window[0] = value;
        if (seen < SEEN_CAP) seen++;
        else if (given > 0) given--;
        waiting = (seen >= given) ? seen - given : 0;
        if (eos) begin
            count = 0;
            while (waiting > 0 && count < MAX_HALF + 1) begin
                push_median(waiting, h, waiting == 1 || count == MAX_HALF);
                waiting--;
                count++;
            end
            seen  = 0;
            given = 0;
        end else if (waiting > h) begin
            push_median(waiting, h, 1'b0);
        end
    endfunction

    task report(string msg);
        $display("MISMATCH: %s", msg);
        error_count++;
    endtask

    // Called for every accepted result transaction.
    task check_result(logic signed [15:0] median, logic last);
        t_expect want;
        results_seen++;
        if (expected_medians.size() == 0) begin
            report($sformatf("result %0d median=%0d last=%0b arrived with none expected",
                             results_seen, median, last));
        end else begin
            want = expected_medians.pop_front();
            if (median !== want.median)
                report($sformatf("result %0d median got %0d want %0d",
                                 results_seen, median, want.median));
            if (last !== want.last)
                report($sformatf("result %0d last_of_run got %0b want %0b",
                                 results_seen, last, want.last));
        end
    endtask

endclass

module sliding_median_filter_tb;
    import smf_pkg::*;

    // A full 17-sample window needs the longest rank search per result, and
    // this many quiet cycles covers any work the block still has in hand.
    localparam int SETTLE_CYCLES  = 350;
    localparam int RX_HOLD_CYCLES = 600;
    localparam int CYCLE_LIMIT    = 3_000_000;
    localparam int ITEM_TARGET    = 240;

    typedef enum int {
        SPREAD_FULL,
        SPREAD_NARROW,
        SPREAD_EXTREME
    } t_spread;

    logic                     i_clk             = 1'b0;
    logic                     i_rst_n           = 1'b0;
    logic                     i_cfg_wr_en       = 1'b0;
    logic [HW_BITS-1:0]       i_cfg_wr_data     = '0;
    logic                     i_valid           = 1'b0;
    logic                     o_ready;
    logic signed [15:0]       i_sample          = '0;
    logic                     i_end_of_spectrum = 1'b0;
    logic                     o_valid;
    logic                     i_ready           = 1'b0;
    logic signed [15:0]       o_median_value;
    logic                     o_last_of_run;

    median_scoreboard results = new();

    // Idling controls shared between the stimulus and the receiver.
    bit          tx_gaps_on      = 1'b1;
    bit          rx_stall_on     = 1'b1;
    bit          rx_hold_request = 1'b0;
    int unsigned rx_hold_left    = 0;
    int unsigned rx_stall_left   = 0;
    int unsigned items_sent      = 0;
    int unsigned cycle_count     = 0;

    sliding_median_filter i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_sample          (i_sample),
        .i_end_of_spectrum (i_end_of_spectrum),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_median_value    (o_median_value),
        .o_last_of_run     (o_last_of_run)
    );

    always #4 i_clk = ~i_clk;

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side. Every result transaction is checked at the edge that
    // accepts it. After each one the receiver draws a short stall, and on
    // request it holds ready low for a long stretch so that the block backs
    // up into its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                results.check_result(o_median_value, o_last_of_run);
                rx_stall_left = rx_stall_on ? $urandom_range(0, 3) : 0;
            end
            if (rx_hold_request) begin
                rx_hold_left    = RX_HOLD_CYCLES;
                rx_hold_request = 1'b0;
            end
            if (rx_hold_left > 0) begin
                i_ready <= 1'b0;
                rx_hold_left--;
            end else if (rx_stall_left > 0) begin
                i_ready <= 1'b0;
                rx_stall_left--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    function automatic logic signed [15:0] draw_sample(t_spread spread);
        int narrow;
        case (spread)
            SPREAD_FULL: begin
                return 16'($urandom);
            end
            SPREAD_NARROW: begin
                // A handful of values, so windows are full of ties.
                narrow = int'($urandom_range(0, 8)) - 4;
                return 16'(narrow);
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: return 16'sh8000;
                    1: return 16'sh7fff;
                    2: return 16'sh0000;
                    default: return 16'shffff;
                endcase
            end
        endcase
    endfunction

    // Offer one sample after a random gap and hold it until it is taken.
    // Valid is only lowered when a gap follows, so back-to-back transactions
    // never see valid dropped and raised within one time step.
    task automatic send_sample(logic signed [15:0] value, logic eos);
        int unsigned gap;
        gap = tx_gaps_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_sample          <= value;
        i_end_of_spectrum <= eos;
        do @(posedge i_clk); while (!o_ready);
        results.note_sample(value, eos);
        items_sent++;
    endtask

    // Stop offering input, wait for every predicted result, then give the
    // block time to finish any sample that produces no result.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (results.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_half_window(logic [HW_BITS-1:0] value);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        results.set_half_window(value);
    endtask

    // One spectrum; a nonzero split_at changes the half window just before
    // that sample, which exercises a mid-spectrum change.
    task automatic send_spectrum(int unsigned len, t_spread spread, int unsigned split_at);
        for (int unsigned n = 1; n <= len; n++) begin
            if (n == split_at) write_half_window(HW_BITS'($urandom_range(0, 15)));
            send_sample(draw_sample(spread), n == len);
        end
    endtask

    initial begin : stimulus
        logic signed [15:0] edge_run [5]  = '{16'sh7fff, 16'sh8000, 16'sh0000,
                                              16'shffff, 16'sh7fff};
        logic signed [15:0] tie_run  [10] = '{16'sd5, 16'sd5, -16'sd3, 16'sd5, -16'sd3,
                                              16'sh7fff, 16'sh8000, 16'sd5, 16'sd5,
                                              -16'sd3};
        int unsigned        len;
        int unsigned        split_at;
        t_spread            spread;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. The reset half window of one first: field extremes
        // and a one-sample spectrum, whose only result is also its last.
        foreach (edge_run[i]) send_sample(edge_run[i], i == 4);
        send_sample(16'sh8000, 1'b1);

        // Half window zero passes samples straight through.
        write_half_window(4'd0);
        send_sample(16'sd1, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sh7fff, 1'b1);

        // A setting above the maximum acts as the maximum; ties everywhere,
        // and the end flag flushes the largest possible tail.
        write_half_window(4'd15);
        foreach (tie_run[i]) send_sample(tie_run[i], i == 9);

        // Shrink the half window in the middle of a spectrum.
        write_half_window(4'd8);
        repeat (4) send_sample(draw_sample(SPREAD_FULL), 1'b0);
        write_half_window(4'd2);
        send_sample(draw_sample(SPREAD_NARROW), 1'b0);
        send_sample(draw_sample(SPREAD_FULL), 1'b1);

        // Back-pressure: the receiver stops for a long stretch while the
        // sender keeps offering a long spectrum without gaps.
        write_half_window(4'd3);
        tx_gaps_on      = 1'b0;
        rx_hold_request = 1'b1;
        send_spectrum(20, SPREAD_FULL, 0);

        // Random phases: each picks a half window and idling pattern, then
        // sends a few spectra. Some spectra are long enough to saturate the
        // sample counter, and some change the half window midway.
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 7) == 0)
                write_half_window(HW_BITS'($urandom_range(9, 15)));
            else
                write_half_window(HW_BITS'($urandom_range(0, 8)));
            tx_gaps_on  = ($urandom_range(0, 3) != 0);
            rx_stall_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 3)) begin
                len      = ($urandom_range(0, 9) == 0) ? $urandom_range(32, 45)
                                                       : $urandom_range(1, 20);
                split_at = ($urandom_range(0, 5) == 0) ? $urandom_range(2, len) : 0;
                case ($urandom_range(0, 5))
                    0:       spread = SPREAD_NARROW;
                    1:       spread = SPREAD_EXTREME;
                    default: spread = SPREAD_FULL;
                endcase
                send_spectrum(len, spread, split_at);
            end
        end

        // Drain everything, then watch a while longer for stray results.
        wait_idle();
        if (results.error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
